// File: sv/dnle_pkg.sv
package dnle_pkg;

	// Width of one encoded byte and of the saturating name length.
	localparam int BYTE_W = 8;

	// Default capacities of one label and of a whole encoded name.
	localparam int MAX_LABEL_DEF = 63;
	localparam int MAX_NAME_DEF  = 255;

	// The character that separates labels.
	localparam logic [BYTE_W-1:0] DOT_CODE = 8'h2E;

	// One character of the dotted name, or the end-of-name mark.
	typedef struct packed {
		logic [BYTE_W-1:0] char_code;
		logic              end_mark;
	} dnle_req_t;

	// One byte of the wire format with its side information.
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last_of_run;
		logic              name_done;
		logic [BYTE_W-1:0] encoded_length;
		logic              label_overflow;
	} dnle_rsp_t;

	// Sequencer states of the encoder.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_LEN,
		ST_CHAR
	} dnle_state_t;

endpackage

// File: sv/dns_name_label_encoder.sv
// Encodes a dotted domain name, one character per request, into DNS wire label
// format. Ordinary characters are written into a label store and give no output;
// characters beyond MAX_LABEL are dropped and raise label_overflow for the rest of
// the name. A dot emits the label length byte followed by the stored characters,
// the final one marked with last_of_run; a dot with no pending characters emits
// nothing. An end-of-name request discards any label not closed by a dot and emits
// the zero root byte with name_done and the total encoded length, saturated at
// MAX_NAME. After a dot is accepted, the length byte and then each stored character
// are emitted in turn through the single read port of the label store, which is
// stepped through one entry per cycle while the output register is free. While bytes
// are being emitted the block stalls its request channel; a full output register
// waiting on a stalled receiver holds the sequencer as well. No clearing pass is
// needed after reset.
module dns_name_label_encoder #(
	parameter int MAX_LABEL = dnle_pkg::MAX_LABEL_DEF,
	parameter int MAX_NAME  = dnle_pkg::MAX_NAME_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  dnle_pkg::dnle_req_t src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output dnle_pkg::dnle_rsp_t dst_data
);

	localparam int CNT_W  = $clog2(MAX_LABEL + 1);
	localparam int ADDR_W = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
	localparam int BW     = dnle_pkg::BYTE_W;

	dnle_pkg::dnle_state_t state_q, state_d;

	logic [CNT_W-1:0]  label_count_q;
	logic [BW-1:0]     total_q;
	logic              ovf_q;
	logic [ADDR_W-1:0] idx_q;
	logic              out_valid_q;
	dnle_pkg::dnle_rsp_t out_q, out_d;

	logic              accept;
	logic              is_dot;
	logic              has_room;
	logic              out_free;
	logic              out_load;
	logic              last_char;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BW-1:0]     ram_rdata;
	logic [BW:0]       label_sum;
	logic [BW:0]       root_sum;
	logic [BW-1:0]     label_total;
	logic [BW-1:0]     root_total;

	// Label store.
	dnle_ram #(
		.WIDTH (BW),
		.DEPTH (MAX_LABEL),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(label_count_q[ADDR_W-1:0]),
		.wdata(src_data.char_code),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Shared decode of the request and of the output register.
	assign is_dot    = (src_data.char_code == dnle_pkg::DOT_CODE);
	assign has_room  = (label_count_q < CNT_W'(MAX_LABEL));
	assign out_free  = !out_valid_q || !dst_stall;
	assign last_char = ((CNT_W'(idx_q) + CNT_W'(1)) == label_count_q);

	// Saturating length arithmetic for a closed label and for the root byte.
	assign label_sum   = {1'b0, total_q} + (BW+1)'(label_count_q) + (BW+1)'(1);
	assign root_sum    = {1'b0, total_q} + (BW+1)'(1);
	assign label_total = (label_sum > (BW+1)'(MAX_NAME)) ? BW'(MAX_NAME) : label_sum[BW-1:0];
	assign root_total  = (root_sum > (BW+1)'(MAX_NAME)) ? BW'(MAX_NAME) : root_sum[BW-1:0];

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dnle_pkg::ST_IDLE: begin
				if (src_valid) begin
					if (src_data.end_mark) begin
						state_d = dnle_pkg::ST_ROOT;
					end else if (is_dot && label_count_q != '0) begin
						state_d = dnle_pkg::ST_LEN;
					end
				end
			end
			dnle_pkg::ST_ROOT: begin
				if (out_free) begin
					state_d = dnle_pkg::ST_IDLE;
				end
			end
			dnle_pkg::ST_LEN: begin
				if (out_free) begin
					state_d = dnle_pkg::ST_CHAR;
				end
			end
			dnle_pkg::ST_CHAR: begin
				if (out_free && last_char) begin
					state_d = dnle_pkg::ST_IDLE;
				end
			end
		endcase
	end

	// Sequencer outputs: handshake, store access and the next result.
	always_comb begin
		src_stall = 1'b1;
		accept    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = '0;
		out_load  = 1'b0;
		out_d     = '{
			out_byte:       '0,
			last_of_run:    1'b0,
			name_done:      1'b0,
			encoded_length: '0,
			label_overflow: ovf_q
		};
		unique case (state_q)
			dnle_pkg::ST_IDLE: begin
				src_stall = 1'b0;
				accept    = src_valid;
				ram_we    = src_valid && !src_data.end_mark && !is_dot && has_room;
			end
			dnle_pkg::ST_ROOT: begin
				out_load             = out_free;
				out_d.last_of_run    = 1'b1;
				out_d.name_done      = 1'b1;
				out_d.encoded_length = root_total;
			end
			dnle_pkg::ST_LEN: begin
				out_load       = out_free;
				out_d.out_byte = BW'(label_count_q);
			end
			dnle_pkg::ST_CHAR: begin
				// Keep reading the current entry until the result is taken.
				ram_raddr         = out_free ? idx_q + ADDR_W'(1) : idx_q;
				out_load          = out_free;
				out_d.out_byte    = ram_rdata;
				out_d.last_of_run = last_char;
			end
		endcase
	end

	// Sequencer state and name bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dnle_pkg::ST_IDLE;
			label_count_q <= '0;
			total_q       <= '0;
			ovf_q         <= 1'b0;
			idx_q         <= '0;
		end else begin
			state_q <= state_d;
			if (accept && !src_data.end_mark && !is_dot) begin
				if (has_room) begin
					label_count_q <= label_count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == dnle_pkg::ST_ROOT && out_free) begin
				label_count_q <= '0;
				total_q       <= '0;
				ovf_q         <= 1'b0;
			end
			if (state_q == dnle_pkg::ST_LEN && out_free) begin
				idx_q <= '0;
			end
			if (state_q == dnle_pkg::ST_CHAR && out_free) begin
				idx_q <= idx_q + ADDR_W'(1);
				if (last_char) begin
					total_q       <= label_total;
					label_count_q <= '0;
				end
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_data  = out_q;

endmodule

// File: sv/dnle_ram.sv
module dnle_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 63,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
